### hw/rtl/sfss_pkg.sv
// Shared types, constants and the seven-segment decode for the frame-to-display scan block.
// Depends on nothing; the receiver, the encoder and the top level import it.
package sfss_pkg;

  // Operation codes carried on the op field.
  localparam logic OP_RX_BYTE   = 1'b0;
  localparam logic OP_SCAN_TICK = 1'b1;

  // Position within a three-byte frame.
  typedef enum logic [1:0] {
    BYTE_SIGN   = 2'd0,
    BYTE_FIRST  = 2'd1,
    BYTE_SECOND = 2'd2,
    BYTE_SPARE  = 2'd3
  } byte_pos_t;

  // Special segment patterns.
  localparam logic [7:0] SEG_MINUS = 8'b0100_0000;
  localparam logic [7:0] SEG_DOT   = 8'b1000_0000;
  localparam logic [7:0] SEG_BLANK = 8'b0000_0000;

  // Scan position that also lights the decimal point.
  localparam logic [1:0] DOT_POSITION = 2'd2;

  // Stored frame contents handed from the receiver to the digit encoder.
  typedef struct packed {
    logic       negative;
    logic [7:0] first_value;
    logic [7:0] second_value;
  } frame_t;

  // Segment pattern for one decimal digit; anything above nine is blank.
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'b0011_1111;
      4'd1:    seg = 8'b0000_0110;
      4'd2:    seg = 8'b0101_1011;
      4'd3:    seg = 8'b0100_1111;
      4'd4:    seg = 8'b0110_0110;
      4'd5:    seg = 8'b0110_1101;
      4'd6:    seg = 8'b0111_1101;
      4'd7:    seg = 8'b0000_0111;
      4'd8:    seg = 8'b0111_1111;
      4'd9:    seg = 8'b0110_1111;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

### hw/rtl/sfss_frame_rx.sv
// Frame receiver: collects sign byte and two value bytes from accepted byte beats.
// Depends on sfss_pkg for the frame position enum and the frame struct.
module sfss_frame_rx
  import sfss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  byte_pos_t  byte_position;
  byte_pos_t  byte_position_next;
  logic       negative_flag;
  logic [7:0] first_value;
  logic [7:0] second_value;

  // Frame position advances on each byte; the spare code behaves as the sign slot.
  always_comb begin
    unique case (byte_position)
      BYTE_FIRST:  byte_position_next = BYTE_SECOND;
      BYTE_SECOND: byte_position_next = BYTE_SIGN;
      default:     byte_position_next = BYTE_FIRST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= BYTE_SIGN;
      negative_flag <= 1'b0;
      first_value   <= '0;
      second_value  <= '0;
    end else if (byte_take) begin
      byte_position <= byte_position_next;
      unique case (byte_position)
        BYTE_FIRST:  first_value   <= rx_byte;
        BYTE_SECOND: second_value  <= rx_byte;
        default:     negative_flag <= (rx_byte != 8'd0);
      endcase
    end
  end

  assign frame.negative     = negative_flag;
  assign frame.first_value  = first_value;
  assign frame.second_value = second_value;

endmodule

### hw/rtl/sfss_digit_enc.sv
// Digit encoder: sums the two value bytes, splits the sum into decimal digits and
// picks the segment pattern for one scan position. Depends on sfss_pkg.
module sfss_digit_enc
  import sfss_pkg::*;
(
  input  frame_t     frame,
  input  logic [1:0] scan_position,
  output logic [3:0] digit_enable_n,
  output logic [7:0] segments
);

  logic [8:0]  sum;
  logic [14:0] hund_prod;
  logic [3:0]  hundreds;
  logic [8:0]  hund_rem;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [7:0]  seg;

  // The sum is at most 510, so the thousands digit is always zero.
  assign sum = {1'b0, frame.first_value} + {1'b0, frame.second_value};

  // Hundreds by reciprocal multiply: floor(sum * 41 / 4096) is exact below 1000.
  assign hund_prod = 15'(sum) * 15'd41;
  assign hundreds  = 4'(hund_prod[14:12]);
  assign hund_rem  = sum - (9'(hundreds) * 9'd100);
  assign rem       = hund_rem[6:0];

  // Tens by reciprocal multiply: floor(rem * 205 / 2048) is exact below 100.
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign units     = 4'(rem - (7'(tens) * 7'd10));

  // Pattern for the scanned position; the first position may show a minus sign.
  always_comb begin
    case (scan_position)
      2'd0:    seg = frame.negative ? SEG_MINUS : digit_pattern(4'd0);
      2'd1:    seg = digit_pattern(hundreds);
      2'd2:    seg = digit_pattern(tens);
      default: seg = digit_pattern(units);
    endcase
  end

  assign segments       = (scan_position == DOT_POSITION) ? (seg | SEG_DOT) : seg;
  assign digit_enable_n = ~(4'b0001 << scan_position);

endmodule

### hw/rtl/spi_frame_to_seven_segment_scan.sv
// Top level of the frame-to-display scan block: handshakes, scan counter, result register.
// Depends on sfss_pkg, sfss_frame_rx and sfss_digit_enc.
//
//   channel   direction   handshake            payload
//   in        sink        in_valid / in_ready  op, rx_byte
//   out       source      out_valid/out_ready  digit_enable_n, segments
//
// One beat is taken per cycle while in_ready is high; a scan tick's result is in the output
// register in the cycle after it is taken, via the single register stage after the encoder.
// A byte beat updates the frame and yields no result.
// Input ready is high whenever the output register is empty or being emptied.
// Reset clears the frame, the scan position and the output valid flag.
module spi_frame_to_seven_segment_scan
  import sfss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] digit_enable_n,
  output logic [7:0] segments
);

  frame_t     frame;
  logic [1:0] scan_position;
  logic       in_take;
  logic       byte_take;
  logic       tick_take;
  logic [3:0] enc_enable_n;
  logic [7:0] enc_segments;

  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;
  assign byte_take = in_take && (op == OP_RX_BYTE);
  assign tick_take = in_take && (op == OP_SCAN_TICK);

  sfss_frame_rx u_frame_rx (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx_byte),
    .frame     (frame)
  );

  sfss_digit_enc u_digit_enc (
    .frame          (frame),
    .scan_position  (scan_position),
    .digit_enable_n (enc_enable_n),
    .segments       (enc_segments)
  );

  // Scan position steps round the four digits on every accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position <= '0;
    end else if (tick_take) begin
      scan_position <= scan_position + 2'd1;
    end
  end

  // Output register: loaded by a tick, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      digit_enable_n <= enc_enable_n;
      segments       <= enc_segments;
    end
  end

endmodule

### hw/rtl/sfss_checker.sv
// Port-level checker for the frame-to-display scan block, bound to the top level.
// Depends only on the top level's ports.
module sfss_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] digit_enable_n,
  input logic [7:0] segments
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_enable_n) && $stable(segments))
    else $error("result beat changed while stalled");

  // Exactly one digit is enabled in every result.
  a_one_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(digit_enable_n) == 3)
    else $error("digit enables not one-cold");

  // The decimal point is lit at the third position only.
  a_dot_third: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (segments[7] == !digit_enable_n[2]))
    else $error("decimal point on wrong position");

  // An empty output register never holds off the input.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Nothing is offered straight after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind spi_frame_to_seven_segment_scan sfss_checker u_sfss_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .digit_enable_n (digit_enable_n),
  .segments       (segments)
);
